### rtl/core/csp_pkg.sv
// Shared types, constants and width helpers for the CFL substep planner.
package csp_pkg;

    localparam int DEF_TIME_FRAC_BITS = 20;
    localparam int DEF_COUNT_BITS     = 16;
    localparam int DEF_QUEUE_DEPTH    = 2;

    localparam logic [31:0] RST_CHAR_LENGTH   = 32'd65536;
    localparam logic [23:0] RST_DISP_FRACTION = 24'd32768;
    localparam logic [31:0] RST_MAX_STEP_TIME = 32'd8738;
    localparam logic [15:0] RST_MAX_SUBSTEPS  = 16'd8;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHAR_LENGTH   = 3'd0,
        REG_DISP_FRACTION = 3'd1,
        REG_MAX_STEP_TIME = 3'd2,
        REG_MAX_SUBSTEPS  = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] char_length;
        logic [23:0] disp_fraction;
        logic [31:0] max_step_time;
        logic [15:0] max_substeps;   // already masked to the count width
    } cfg_t;

    typedef struct packed {
        logic        inval;
        logic [31:0] frame;
        logic [30:0] speed;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL,
        ST_MDIV_GO,
        ST_MDIV_WAIT,
        ST_CDIV_GO,
        ST_CDIV_WAIT,
        ST_SDIV_GO,
        ST_SDIV_WAIT,
        ST_MUL2,
        ST_FDIV_GO,
        ST_FDIV_WAIT,
        ST_DONE
    } back_state_t;

    function automatic int csp_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Left shift applied to time values when the time format is finer than Q16.
    function automatic int csp_up(input int tfb);
        return (tfb >= 16) ? tfb - 16 : 0;
    endfunction

    function automatic int csp_dn(input int tfb);
        return (tfb < 16) ? 16 - tfb : 0;
    endfunction

    // Dividend width covering the motion, count, step and CFL divisions.
    function automatic int csp_nw(input int tfb);
        return csp_max(csp_max(56 + csp_up(tfb), 63 + csp_dn(tfb)), 33);
    endfunction

    function automatic int csp_dw(input int tfb);
        return csp_max(csp_max(31 + csp_dn(tfb), 32 + csp_up(tfb)), 32);
    endfunction

endpackage

### rtl/core/csp_fifo.sv
// Short queue of classified frame items between the front and the back.
module csp_fifo
    import csp_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [ITEM_W-1:0] push_data,
    input  logic              pop,
    output logic [ITEM_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ITEM_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/csp_div.sv
// Radix-2 restoring divider giving a 32-bit quotient saturated at all ones.
module csp_div
    import csp_pkg::*;
#(
    parameter int NW = 70,
    parameter int DW = 38
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [31:0]   quot
);

    localparam int HW = NW - 32;
    localparam int CW = csp_max(HW, DW);

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [31:0]   sh_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign hi_ext  = CW'(num[NW-1:32]);
    assign den_ext = CW'(den);
    assign trial   = {rem_reg, sh_reg[31]};
    assign ge      = trial >= {1'b0, den_reg};
    assign diff    = trial - {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = sh_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            if (hi_ext >= den_ext) begin
                sh_reg <= '1;
            end else begin
                // The high part is below the divisor, so it fits the remainder.
                rem_reg <= DW'(num[NW-1:32]);
                sh_reg  <= num[31:0];
            end
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            sh_reg  <= {sh_reg[30:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (hi_ext >= den_ext) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 6'd32;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/csp_front.sv
// Front end: configuration registers, input acceptance and plan validity check.
module csp_front
    import csp_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    output logic                   q_push,
    output logic [ITEM_W-1:0]      q_data,
    input  logic                   q_full,
    output cfg_t                   cfg
);

    localparam int MSK_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    logic [31:0] char_length_reg;
    logic [23:0] disp_fraction_reg;
    logic [31:0] max_step_time_reg;
    logic [15:0] max_substeps_reg;
    logic [15:0] maxsub;
    logic [31:0] frame;
    logic [31:0] speed;
    item_t       item;

    assign cfg_ready = 1'b1;
    assign maxsub    = 16'(max_substeps_reg[MSK_W-1:0]);
    assign frame     = s_tdata[31:0];
    assign speed     = s_tdata[63:32];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_length_reg   <= RST_CHAR_LENGTH;
            disp_fraction_reg <= RST_DISP_FRACTION;
            max_step_time_reg <= RST_MAX_STEP_TIME;
            max_substeps_reg  <= RST_MAX_SUBSTEPS;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_CHAR_LENGTH: begin
                    char_length_reg <= cfg_data;
                end
                REG_DISP_FRACTION: begin
                    disp_fraction_reg <= cfg_data[23:0];
                end
                REG_MAX_STEP_TIME: begin
                    max_step_time_reg <= cfg_data;
                end
                REG_MAX_SUBSTEPS: begin
                    max_substeps_reg <= cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.char_length   = char_length_reg;
        cfg.disp_fraction = disp_fraction_reg;
        cfg.max_step_time = max_step_time_reg;
        cfg.max_substeps  = maxsub;
    end

    // Any zero setting, a zero frame or a negative speed yields an all-zero plan.
    always_comb begin
        item.inval = (frame == '0) || (char_length_reg == '0) ||
                     (disp_fraction_reg == '0) || (max_step_time_reg == '0) ||
                     (maxsub == '0) || speed[31];
        item.frame = frame;
        item.speed = speed[30:0];
    end

    assign q_data   = item;
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

### rtl/core/csp_back.sv
// Back end: sequences the multiplies and divisions of one plan and holds the result beat.
module csp_back
    import csp_pkg::*;
#(
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    output logic                                  q_pop,
    input  logic [ITEM_W-1:0]                     q_data,
    input  cfg_t                                  cfg,
    output logic                                  div_start,
    output logic [csp_nw(TIME_FRAC_BITS)-1:0]     div_num,
    output logic [csp_dw(TIME_FRAC_BITS)-1:0]     div_den,
    input  logic                                  div_done,
    input  logic [31:0]                           div_quot,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [111:0]                          m_tdata,
    output logic [1:0]                            m_tuser
);

    localparam int UP = csp_up(TIME_FRAC_BITS);
    localparam int DN = csp_dn(TIME_FRAC_BITS);
    localparam int NW = csp_nw(TIME_FRAC_BITS);
    localparam int DW = csp_dw(TIME_FRAC_BITS);

    back_state_t state_reg;
    back_state_t state_next;
    item_t       item;
    logic [31:0] frame_reg;
    logic [30:0] speed_reg;
    logic        inval_reg;
    logic [62:0] prod_reg;
    logic [31:0] req_reg;
    logic [15:0] count_reg;
    logic        clamp_reg;
    logic [31:0] step_reg;
    logic [31:0] cfl_reg;
    logic [31:0] safe;
    logic        out_free;
    logic        m_valid_reg;
    logic [111:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        raw_clamp;

    assign item      = item_t'(q_data);
    assign safe      = (req_reg == '0) ? 32'd1 : req_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign raw_clamp = div_quot > 32'(cfg.max_substeps);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) state_next = ST_SEL;
            end
            ST_SEL: begin
                if (inval_reg) begin
                    state_next = ST_DONE;
                end else if (speed_reg == '0) begin
                    state_next = ST_CDIV_GO;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_MDIV_GO;
            ST_MDIV_GO:   state_next = ST_MDIV_WAIT;
            ST_MDIV_WAIT: begin
                if (div_done) state_next = ST_CDIV_GO;
            end
            ST_CDIV_GO:   state_next = ST_CDIV_WAIT;
            ST_CDIV_WAIT: begin
                if (div_done) state_next = ST_SDIV_GO;
            end
            ST_SDIV_GO:   state_next = ST_SDIV_WAIT;
            ST_SDIV_WAIT: begin
                if (div_done) state_next = ST_MUL2;
            end
            ST_MUL2:      state_next = ST_FDIV_GO;
            ST_FDIV_GO:   state_next = ST_FDIV_WAIT;
            ST_FDIV_WAIT: begin
                if (div_done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = !q_empty;
            end
            ST_MDIV_GO: begin
                div_start = 1'b1;
                div_num   = NW'(prod_reg[55:0]) << UP;
                div_den   = DW'(speed_reg) << DN;
            end
            ST_CDIV_GO: begin
                // Ceiling division: (frame + safe - 1) / safe.
                div_start = 1'b1;
                div_num   = NW'({1'b0, frame_reg} + {1'b0, safe} - 33'd1);
                div_den   = DW'(safe);
            end
            ST_SDIV_GO: begin
                div_start = 1'b1;
                div_num   = NW'(frame_reg);
                div_den   = DW'(count_reg);
            end
            ST_FDIV_GO: begin
                div_start = 1'b1;
                div_num   = NW'(prod_reg) << DN;
                div_den   = DW'(cfg.char_length) << UP;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                frame_reg <= item.frame;
                speed_reg <= item.speed;
                inval_reg <= item.inval;
            end
            ST_SEL: begin
                if (inval_reg) begin
                    req_reg   <= '0;
                    count_reg <= '0;
                    clamp_reg <= 1'b0;
                    step_reg  <= '0;
                    cfl_reg   <= '0;
                end else if (speed_reg == '0) begin
                    req_reg <= cfg.max_step_time;
                end
            end
            ST_MUL: begin
                prod_reg <= 63'(cfg.disp_fraction) * 63'(cfg.char_length);
            end
            ST_MDIV_WAIT: begin
                if (div_done) begin
                    req_reg <= (div_quot < cfg.max_step_time) ? div_quot : cfg.max_step_time;
                end
            end
            ST_CDIV_WAIT: begin
                if (div_done) begin
                    clamp_reg <= raw_clamp;
                    count_reg <= raw_clamp ? cfg.max_substeps : div_quot[15:0];
                end
            end
            ST_SDIV_WAIT: begin
                if (div_done) step_reg <= div_quot;
            end
            ST_MUL2: begin
                prod_reg <= 63'(speed_reg) * 63'(step_reg);
            end
            ST_FDIV_WAIT: begin
                if (div_done) cfl_reg <= div_quot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {cfl_reg, req_reg, step_reg, count_reg};
            m_tuser_reg <= {clamp_reg, !inval_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/cfl_substep_planner.sv
// Top level of the CFL-limited substep planner.
//
// Input stream: one beat per frame, s_tdata = {peak_speed[63:32], frame_time[31:0]}.
// Output stream: one plan beat per input beat, in order. m_tdata carries
// step_count, step_time, requested_time and cfl_estimate from the low bits up;
// m_tuser carries plan_valid (bit 0) and count_clamped (bit 1).
// Settings are written over the cfg channel (index 0 char_length, 1 disp_fraction,
// 2 max_step_time, 3 max_substeps), which is always ready; write them only while
// no frame is in flight.
// A frame with an invalid plan skips all arithmetic; otherwise up to four
// divisions (motion limit, count, step time, CFL) share one radix-2 divider,
// plus up to two multiplies. The back finishes one frame before it takes the
// next, so the shared divider sets the sustained plan rate.
// The front accepts new frames into a QUEUE_DEPTH-entry queue (two by default) while the back works, and
// a finished plan waits in the output register while the next one is computed.
// When the receiver stalls, the back holds its finished plan and the queue fills,
// then s_tready drops. Reset empties the queue and output and restores defaults.
module cfl_substep_planner
    import csp_pkg::*;
#(
    parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS,
    parameter int COUNT_BITS     = DEF_COUNT_BITS,
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // frame_time, peak_speed
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [111:0]           m_tdata,   // step_count, step_time, requested_time, cfl_estimate
    output logic [1:0]             m_tuser,   // plan_valid, count_clamped
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int NW = csp_nw(TIME_FRAC_BITS);
    localparam int DW = csp_dw(TIME_FRAC_BITS);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [ITEM_W-1:0] q_in;
    logic [ITEM_W-1:0] q_out;
    cfg_t              cfg;
    logic              div_start;
    logic              div_done;
    logic [NW-1:0]     div_num;
    logic [DW-1:0]     div_den;
    logic [31:0]       div_quot;

    csp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full),
        .cfg       (cfg)
    );

    csp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    csp_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    csp_back #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_out),
        .cfg       (cfg),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quot  (div_quot),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
